/* design/pcicap_pkg.sv */
package pcicap_pkg;

    localparam int FUNCTIONS       = 8;
    localparam int MAX_HOPS        = 64;
    localparam int WORDS_PER_IMAGE = 64;

    localparam int FN_W     = 3;
    localparam int WORD_W   = 6;
    localparam int DATA_W   = 32;
    localparam int ID_W     = 8;
    localparam int OFFSET_W = 8;

    localparam int MEM_DEPTH = FUNCTIONS * WORDS_PER_IMAGE;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int HOP_W     = $clog2(MAX_HOPS + 1);

    localparam logic [FN_W:0]       FN_LIMIT     = (FN_W + 1)'(FUNCTIONS);
    localparam logic [HOP_W-1:0]    HOP_LIMIT    = HOP_W'(MAX_HOPS);
    localparam logic [WORD_W-1:0]   STATUS_WORD  = 6'd1;
    localparam logic [WORD_W-1:0]   CAPPTR_WORD  = 6'd13;
    localparam int                  CAPLIST_BIT  = 20;
    localparam logic [OFFSET_W-1:0] PTR_MASK     = 8'hFC;
    localparam logic [OFFSET_W-1:0] HEADER_END   = 8'h40;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [FN_W-1:0]   fn,
                                                    input logic [WORD_W-1:0] word);
        return ADDR_W'({fn, word});
    endfunction

endpackage

/* design/pcicap_store.sv */
module pcicap_store (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pcicap_pkg::mem_req_t                req,
    output logic [pcicap_pkg::DATA_W-1:0]       rdata,
    output logic                                busy
);
    import pcicap_pkg::*;

    logic [DATA_W-1:0] mem_arr [MEM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              busy_reg, busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

    // clearing sweep runs once after reset, one word per cycle
    always_comb begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem_arr[clr_cnt_reg] <= '0;
        end else if (req.we) begin
            mem_arr[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem_arr[req.raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

    a_no_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.we)
        else $error("image write during clearing sweep");

    a_clear_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> !busy_reg)
        else $error("clearing sweep restarted without reset");

    a_clear_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && clr_cnt_reg != LAST_ADDR) |=>
            (busy_reg && clr_cnt_reg == $past(clr_cnt_reg) + 1'b1))
        else $error("clearing sweep skipped or stalled");

endmodule

/* design/pci_capability_list_walker.sv */
// Channel  Ports                                   Direction  Moves
// s_       s_valid/s_ready, s_operation..wanted_id  in         write or search transaction
// m_       m_valid/m_ready, m_found, m_capability_offset out   one result per search
//
// Write: taken in idle; no result.
// Search: accept, status read, pointer read, one read per list entry visited, then
//   staging. Each step waits on the one image RAM read port.
// After reset all 512 words of the image RAM are swept to zero with s_ready low.
// A result waiting on m_ready holds the walker in its staging state; writes are
// taken again once the result moves into the output register.
module pci_capability_list_walker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [pcicap_pkg::FN_W-1:0]           s_function_select,
    input  logic [pcicap_pkg::WORD_W-1:0]         s_word_index,
    input  logic [pcicap_pkg::DATA_W-1:0]         s_word_data,
    input  logic [pcicap_pkg::ID_W-1:0]           s_wanted_id,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic [pcicap_pkg::OFFSET_W-1:0]       m_capability_offset
);
    import pcicap_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STAT = 5'b00010,
        ST_CPTR = 5'b00100,
        ST_HOP  = 5'b01000,
        ST_POST = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [FN_W-1:0]     fn_reg, fn_next;
    logic [ID_W-1:0]     want_reg, want_next;
    logic [OFFSET_W-1:0] ptr_reg, ptr_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic                rfound_reg, rfound_next;
    logic [OFFSET_W-1:0] roff_reg, roff_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg;
    logic [OFFSET_W-1:0] m_off_reg;

    mem_req_t            req;
    logic [DATA_W-1:0]   rdata;
    logic                clr_busy;

    logic                fn_ok;
    logic                out_free;
    logic [OFFSET_W-1:0] cand;
    logic [OFFSET_W-1:0] cand_m;
    logic [HOP_W-1:0]    hop_cur;
    logic                walk_stop;

    pcicap_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rdata   (rdata),
        .busy    (clr_busy)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign fn_ok    = {1'b0, s_function_select} < FN_LIMIT;
    assign out_free = !m_valid_reg || m_ready;

    // next pointer: capability pointer byte on the first hop, else the next-link byte
    assign cand      = (state_reg == ST_HOP) ? rdata[15:8] : rdata[7:0];
    assign cand_m    = cand & PTR_MASK;
    assign hop_cur   = (state_reg == ST_HOP) ? hop_reg + 1'b1 : '0;
    assign walk_stop = (hop_cur >= HOP_LIMIT) || (cand == '0) || (cand_m < HEADER_END);

    always_comb begin
        state_next  = state_reg;
        fn_next     = fn_reg;
        want_next   = want_reg;
        ptr_next    = ptr_reg;
        hop_next    = hop_reg;
        rfound_next = rfound_reg;
        roff_next   = roff_reg;
        req         = '0;
        req.raddr   = word_addr(fn_reg, ptr_reg[7:2]);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (!s_operation) begin
                        req.we    = fn_ok;
                        req.waddr = word_addr(s_function_select, s_word_index);
                        req.wdata = s_word_data;
                    end else begin
                        fn_next   = s_function_select;
                        want_next = s_wanted_id;
                        if (fn_ok) begin
                            req.raddr  = word_addr(s_function_select, STATUS_WORD);
                            state_next = ST_STAT;
                        end else begin
                            rfound_next = 1'b0;
                            roff_next   = '0;
                            state_next  = ST_POST;
                        end
                    end
                end
            end
            ST_STAT: begin
                if (!rdata[CAPLIST_BIT]) begin
                    rfound_next = 1'b0;
                    roff_next   = '0;
                    state_next  = ST_POST;
                end else begin
                    req.raddr  = word_addr(fn_reg, CAPPTR_WORD);
                    state_next = ST_CPTR;
                end
            end
            ST_CPTR, ST_HOP: begin
                if ((state_reg == ST_HOP) && (rdata[7:0] == want_reg)) begin
                    rfound_next = 1'b1;
                    roff_next   = ptr_reg;
                    state_next  = ST_POST;
                end else if (walk_stop) begin
                    rfound_next = 1'b0;
                    roff_next   = '0;
                    state_next  = ST_POST;
                end else begin
                    ptr_next   = cand_m;
                    hop_next   = hop_cur;
                    req.raddr  = word_addr(fn_reg, cand_m[7:2]);
                    state_next = ST_HOP;
                end
            end
            ST_POST: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_POST) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fn_reg     <= fn_next;
        want_reg   <= want_next;
        ptr_reg    <= ptr_next;
        hop_reg    <= hop_next;
        rfound_reg <= rfound_next;
        roff_reg   <= roff_next;
        if ((state_reg == ST_POST) && out_free) begin
            m_found_reg <= rfound_reg;
            m_off_reg   <= roff_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_found             = m_found_reg;
    assign m_capability_offset = m_off_reg;

    a_found_offset_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |->
            (m_capability_offset >= HEADER_END && m_capability_offset[1:0] == 2'b00))
        else $error("found capability at illegal offset");

    a_miss_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_capability_offset == '0))
        else $error("miss reported with nonzero offset");

    a_hop_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOP) |-> (hop_reg < HOP_LIMIT && ptr_reg >= HEADER_END))
        else $error("walk beyond hop limit or into header");

    a_post_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POST && !out_free) |=> (state_reg == ST_POST))
        else $error("staged result dropped while output stalled");

endmodule

/* tb/pci_capability_list_walker_checker.sv */
`timescale 1ns / 100ps

package pcicap_tb_pkg;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_e;

    typedef struct packed {
        logic       found;
        logic [7:0] offset;
    } cap_hit_t;

endpackage

module pci_capability_list_walker_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_operation,
    input  logic [pcicap_pkg::FN_W-1:0]     s_function_select,
    input  logic [pcicap_pkg::WORD_W-1:0]   s_word_index,
    input  logic [pcicap_pkg::DATA_W-1:0]   s_word_data,
    input  logic [pcicap_pkg::ID_W-1:0]     s_wanted_id,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_found,
    input  logic [pcicap_pkg::OFFSET_W-1:0] m_capability_offset,
    output int                              mismatches,
    output int                              pending
);
    import pcicap_pkg::*;
    import pcicap_tb_pkg::*;

    logic [DATA_W-1:0] image_mem [FUNCTIONS][WORDS_PER_IMAGE];
    cap_hit_t          hit_q [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [7:0] image_byte(input logic [FN_W-1:0] fn,
                                              input logic [7:0] addr);
        logic [DATA_W-1:0] word;
        word = image_mem[fn][addr[7:2]];
        return word[addr[1:0]*8 +: 8];
    endfunction

    // Follow the capability chain the same way the walker does: mask, bounds check, compare.
    function automatic cap_hit_t walk_list(input logic [FN_W-1:0] fn,
                                           input logic [ID_W-1:0] want);
        cap_hit_t   res;
        logic [7:0] ptr;
        logic [7:0] id_byte;
        logic [7:0] link_ptr;
        res = '0;
        if (!image_mem[fn][STATUS_WORD][CAPLIST_BIT])
            return res;
        ptr = image_byte(fn, {CAPPTR_WORD, 2'b00});
        for (int hop = 0; hop < MAX_HOPS && ptr != 8'h00; hop++) begin
            ptr = ptr & PTR_MASK;
            if (ptr < HEADER_END)
                break;
            id_byte  = image_byte(fn, ptr);
            link_ptr = image_byte(fn, ptr + 8'd1);
            if (id_byte == want) begin
                res.found  = 1'b1;
                res.offset = ptr;
                return res;
            end
            ptr = link_ptr;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cap_hit_t got;
        cap_hit_t wanted;
        if (!aresetn) begin
            for (int f = 0; f < FUNCTIONS; f++)
                for (int w = 0; w < WORDS_PER_IMAGE; w++)
                    image_mem[f][w] = '0;
            hit_q.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_found, m_capability_offset};
                if (hit_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result found=%0d offset=%02h",
                                 $realtime, got.found, got.offset);
                end else begin
                    wanted = hit_q.pop_front();
                    if (got != wanted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp found=%0d off=%02h got found=%0d off=%02h",
                                     $realtime, wanted.found, wanted.offset,
                                     got.found, got.offset);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_SEARCH)
                    hit_q.push_back(walk_list(s_function_select, s_wanted_id));
                else
                    image_mem[s_function_select][s_word_index] = s_word_data;
            end
            pending <= hit_q.size();
        end
    end

endmodule

/* tb/pci_capability_list_walker_tb.sv */
`timescale 1ns / 100ps

module pci_capability_list_walker_tb;
    import pcicap_pkg::*;
    import pcicap_tb_pkg::*;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic                s_operation       = OP_WRITE;
    logic [FN_W-1:0]     s_function_select = '0;
    logic [WORD_W-1:0]   s_word_index      = '0;
    logic [DATA_W-1:0]   s_word_data       = '0;
    logic [ID_W-1:0]     s_wanted_id       = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic                m_found;
    logic [OFFSET_W-1:0] m_capability_offset;

    int mismatches;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int ready_left = 0;

    pci_capability_list_walker dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_function_select   (s_function_select),
        .s_word_index        (s_word_index),
        .s_word_data         (s_word_data),
        .s_wanted_id         (s_wanted_id),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_found             (m_found),
        .m_capability_offset (m_capability_offset)
    );

    pci_capability_list_walker_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_function_select   (s_function_select),
        .s_word_index        (s_word_index),
        .s_word_data         (s_word_data),
        .s_wanted_id         (s_wanted_id),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_found             (m_found),
        .m_capability_offset (m_capability_offset),
        .mismatches          (mismatches),
        .pending             (pending)
    );

    always #6 aclk = ~aclk;

    // Receiver: short stalls between runs of ready, now and then a long stall-free run.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(1, 8);
            end else begin
                m_ready <= 1'b1;
                ready_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
            end
        end else begin
            ready_left--;
        end
    end

    initial begin
        #20_000_000;
        $display("pci_capability_list_walker_tb: errors");
        $finish;
    end

    task automatic send_item(input op_e op, input logic [FN_W-1:0] fn,
                             input logic [WORD_W-1:0] widx, input logic [DATA_W-1:0] data,
                             input logic [ID_W-1:0] want);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        s_valid           <= 1'b1;
        s_operation       <= op;
        s_function_select <= fn;
        s_word_index      <= widx;
        s_word_data       <= data;
        s_wanted_id       <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_word(input logic [FN_W-1:0] fn, input logic [WORD_W-1:0] widx,
                              input logic [DATA_W-1:0] data);
        send_item(OP_WRITE, fn, widx, data, ID_W'($urandom));
    endtask

    task automatic search(input logic [FN_W-1:0] fn, input logic [ID_W-1:0] want);
        send_item(OP_SEARCH, fn, WORD_W'($urandom), $urandom, want);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int          slot [48];
        logic [7:0]  ids [48];
        int          n;
        int          j;
        int          tmp;
        int          choice;
        logic [31:0] data;
        logic [2:0]  fn;
        logic [7:0]  link_ptr;
        bit          drained;

        drained = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // capability bit still clear after reset
        search(3'd0, 8'h00);
        write_word(3'd0, STATUS_WORD, 32'h0010_0000);
        write_word(3'd0, CAPPTR_WORD, 32'h0000_0040);
        write_word(3'd0, 6'd16, 32'h0000_0005);
        search(3'd0, 8'h05);
        search(3'd0, 8'hFF);
        write_word(3'd0, STATUS_WORD, 32'hFFEF_FFFF);
        search(3'd0, 8'h05);
        write_word(3'd0, STATUS_WORD, 32'hFFFF_FFFF);
        // pointer into the header region ends the walk
        write_word(3'd0, CAPPTR_WORD, 32'hFFFF_FF3F);
        search(3'd0, 8'h3F);
        // entry at 0xFC points at itself: hit, then hop limit on a miss
        write_word(3'd0, CAPPTR_WORD, 32'h0000_00FF);
        write_word(3'd0, 6'd63, 32'hFFFF_FE00);
        search(3'd0, 8'h00);
        search(3'd0, 8'hFF);
        // two-entry chain with unaligned pointers, ends on a small nonzero pointer
        write_word(3'd0, CAPPTR_WORD, 32'h0000_0043);
        write_word(3'd0, 6'd16, 32'h1234_7FAA);
        write_word(3'd0, 6'd31, 32'h0000_0177);
        search(3'd0, 8'h77);
        search(3'd0, 8'hAB);
        write_word(3'd7, 6'd63, 32'hFFFF_FFFF);
        search(3'd7, 8'hFF);
        write_word(3'd7, 6'd0, 32'h0000_0000);

        while (items_sent < 1220) begin
            if (!drained && items_sent >= 600) begin
                drain();
                drained = 1'b1;
            end
            choice = $urandom_range(0, 9);
            if (choice < 6) begin
                // well-formed list in random slots, then a few searches
                fn = 3'($urandom_range(0, 7));
                n  = ($urandom_range(0, 15) == 0) ? 48 : $urandom_range(1, 10);
                for (int i = 0; i < 48; i++)
                    slot[i] = 16 + i;
                for (int i = 47; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = slot[i];
                    slot[i] = slot[j];
                    slot[j] = tmp;
                end
                data = $urandom;
                data[CAPLIST_BIT] = ($urandom_range(0, 9) != 0);
                write_word(fn, STATUS_WORD, data);
                data = $urandom;
                data[7:0] = 8'(slot[0] * 4 + $urandom_range(0, 3));
                write_word(fn, CAPPTR_WORD, data);
                for (int i = 0; i < n; i++) begin
                    ids[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7))
                                                         : 8'($urandom);
                    if (i < n - 1) begin
                        link_ptr = 8'(slot[i + 1] * 4 + $urandom_range(0, 3));
                    end else begin
                        case ($urandom_range(0, 2))
                            0: link_ptr = 8'h00;
                            1: link_ptr = 8'($urandom_range(1, 8'h3F));
                            default: link_ptr = 8'(slot[$urandom_range(0, i)] * 4
                                                   + $urandom_range(0, 3));
                        endcase
                    end
                    data = $urandom;
                    data[7:0]  = ids[i];
                    data[15:8] = link_ptr;
                    write_word(fn, WORD_W'(slot[i]), data);
                end
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) < 7)
                        search(fn, ids[$urandom_range(0, n - 1)]);
                    else
                        search(fn, 8'($urandom));
                end
            end else if (choice < 8) begin
                write_word(3'($urandom), 6'($urandom), $urandom);
            end else begin
                search(3'($urandom), 8'($urandom));
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("pci_capability_list_walker_tb: clean");
        else
            $display("pci_capability_list_walker_tb: errors");
        $finish;
    end

endmodule
